// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the shading pipeline.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define FSF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication with a fixed delay in cycles.
`define FSF_ASSERT_DLY(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

// ----- sv/fsf_pkg.sv -----
// ---------------------------------------------------------------------------
// fsf_pkg
// Types and constants of the flat-shading face intensity pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fsf_pkg;

  localparam int CW   = 16;   // config and vertex width
  localparam int EW   = 17;   // edge vector width
  localparam int NW   = 34;   // normal component width (signed)
  localparam int NMW  = 33;   // normal magnitude width
  localparam int SQW  = 66;   // squared normal component
  localparam int LW   = 68;   // |n|^2
  localparam int DW   = 51;   // dot product (signed)
  localparam int MW   = 50;   // |dot|
  localparam int HW   = 25;   // half of |dot| for the split square
  localparam int HPW  = 50;   // partial product of halves
  localparam int PW   = 101;  // root search accumulators and |dot|^2
  localparam int QW   = 16;   // intensity width
  localparam int LAT  = 23;   // request to result, in cycles

  typedef enum logic [1:0] {
    REG_LIGHT_X = 2'd0,
    REG_LIGHT_Y = 2'd1,
    REG_LIGHT_Z = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] az;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] bz;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;
  } tri_t;

  typedef struct packed {
    logic [QW-1:0] intensity;
    logic          degenerate;
  } shade_t;

  // Hand-off from the dot/length stages to the root search.
  typedef struct packed {
    logic          valid;
    logic          degenerate;
    logic [LW-1:0] len2;
    logic [PW-1:0] d2;
  } root_in_t;

endpackage

// ----- sv/fsf_front.sv -----
// ---------------------------------------------------------------------------
// fsf_front
// Edge vectors, cross-product terms and face normal in three stages.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsf_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  fsf_pkg::tri_t                     in_tri,
  output logic                              n_valid,
  output logic signed [fsf_pkg::NW-1:0]     nx,
  output logic signed [fsf_pkg::NW-1:0]     ny,
  output logic signed [fsf_pkg::NW-1:0]     nz
);

  logic signed [fsf_pkg::EW-1:0] ex_r, ey_r, ez_r, fx_r, fy_r, fz_r;
  logic signed [fsf_pkg::EW-1:0] ex_nxt, ey_nxt, ez_nxt, fx_nxt, fy_nxt, fz_nxt;
  logic signed [fsf_pkg::NW-1:0] p_r [6];
  logic signed [fsf_pkg::NW-1:0] p_nxt [6];
  logic signed [fsf_pkg::NW-1:0] nx_r, ny_r, nz_r;
  logic signed [fsf_pkg::NW-1:0] nx_nxt, ny_nxt, nz_nxt;
  logic                          v1_r, v2_r, v3_r;

  always_comb begin
    ex_nxt = fsf_pkg::EW'(in_tri.bx) - fsf_pkg::EW'(in_tri.ax);
    ey_nxt = fsf_pkg::EW'(in_tri.by) - fsf_pkg::EW'(in_tri.ay);
    ez_nxt = fsf_pkg::EW'(in_tri.bz) - fsf_pkg::EW'(in_tri.az);
    fx_nxt = fsf_pkg::EW'(in_tri.cx) - fsf_pkg::EW'(in_tri.ax);
    fy_nxt = fsf_pkg::EW'(in_tri.cy) - fsf_pkg::EW'(in_tri.ay);
    fz_nxt = fsf_pkg::EW'(in_tri.cz) - fsf_pkg::EW'(in_tri.az);
  end

  always_comb begin
    p_nxt[0] = fsf_pkg::NW'(ey_r) * fsf_pkg::NW'(fz_r);
    p_nxt[1] = fsf_pkg::NW'(ez_r) * fsf_pkg::NW'(fy_r);
    p_nxt[2] = fsf_pkg::NW'(ez_r) * fsf_pkg::NW'(fx_r);
    p_nxt[3] = fsf_pkg::NW'(ex_r) * fsf_pkg::NW'(fz_r);
    p_nxt[4] = fsf_pkg::NW'(ex_r) * fsf_pkg::NW'(fy_r);
    p_nxt[5] = fsf_pkg::NW'(ey_r) * fsf_pkg::NW'(fx_r);
  end

  always_comb begin
    nx_nxt = p_r[0] - p_r[1];
    ny_nxt = p_r[2] - p_r[3];
    nz_nxt = p_r[4] - p_r[5];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    ex_r <= ex_nxt;
    ey_r <= ey_nxt;
    ez_r <= ez_nxt;
    fx_r <= fx_nxt;
    fy_r <= fy_nxt;
    fz_r <= fz_nxt;
    for (int i = 0; i < 6; i++) begin
      p_r[i] <= p_nxt[i];
    end
    nx_r <= nx_nxt;
    ny_r <= ny_nxt;
    nz_r <= nz_nxt;
  end

  assign n_valid = v3_r;
  assign nx      = nx_r;
  assign ny      = ny_r;
  assign nz      = nz_r;

endmodule

// ----- sv/fsf_dot.sv -----
// ---------------------------------------------------------------------------
// fsf_dot
// Dot product with the light, squared normal length and squared dot,
// in four stages.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsf_dot (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              n_valid,
  input  logic signed [fsf_pkg::NW-1:0]     nx,
  input  logic signed [fsf_pkg::NW-1:0]     ny,
  input  logic signed [fsf_pkg::NW-1:0]     nz,
  input  logic signed [fsf_pkg::CW-1:0]     light_x,
  input  logic signed [fsf_pkg::CW-1:0]     light_y,
  input  logic signed [fsf_pkg::CW-1:0]     light_z,
  output fsf_pkg::root_in_t                 rin
);

  // stage 4
  logic signed [fsf_pkg::DW-1:0]  pd_r [3];
  logic signed [fsf_pkg::DW-1:0]  pd_nxt [3];
  logic        [fsf_pkg::NMW-1:0] nm_r [3];
  logic        [fsf_pkg::NMW-1:0] nm_nxt [3];
  // stage 5
  logic        [fsf_pkg::MW-1:0]  dmag_r, dmag_nxt;
  logic signed [fsf_pkg::DW-1:0]  dsum;
  logic        [fsf_pkg::SQW-1:0] sq_r [3];
  logic        [fsf_pkg::SQW-1:0] sq_nxt [3];
  // stage 6
  logic        [fsf_pkg::LW-1:0]  len2_r, len2_nxt;
  logic        [fsf_pkg::HW-1:0]  dh, dl;
  logic        [fsf_pkg::HPW-1:0] hh_r, hl_r, ll_r, hh_nxt, hl_nxt, ll_nxt;
  // stage 7
  logic        [fsf_pkg::LW-1:0]  len2b_r;
  logic        [fsf_pkg::PW-1:0]  d2_r, d2_nxt;
  logic                           deg_r, deg_nxt;
  logic                           v4_r, v5_r, v6_r, v7_r;

  always_comb begin
    pd_nxt[0] = fsf_pkg::DW'(nx) * fsf_pkg::DW'(light_x);
    pd_nxt[1] = fsf_pkg::DW'(ny) * fsf_pkg::DW'(light_y);
    pd_nxt[2] = fsf_pkg::DW'(nz) * fsf_pkg::DW'(light_z);
    nm_nxt[0] = nx[fsf_pkg::NW-1] ? fsf_pkg::NMW'(-nx) : fsf_pkg::NMW'(nx);
    nm_nxt[1] = ny[fsf_pkg::NW-1] ? fsf_pkg::NMW'(-ny) : fsf_pkg::NMW'(ny);
    nm_nxt[2] = nz[fsf_pkg::NW-1] ? fsf_pkg::NMW'(-nz) : fsf_pkg::NMW'(nz);
  end

  always_comb begin
    dsum     = pd_r[0] + pd_r[1] + pd_r[2];
    dmag_nxt = dsum[fsf_pkg::DW-1] ? fsf_pkg::MW'(-dsum) : fsf_pkg::MW'(dsum);
    for (int i = 0; i < 3; i++) begin
      sq_nxt[i] = fsf_pkg::SQW'(nm_r[i]) * fsf_pkg::SQW'(nm_r[i]);
    end
  end

  // |d|^2 is split into halves to keep each multiplier narrow
  always_comb begin
    dh       = dmag_r[fsf_pkg::MW-1:fsf_pkg::HW];
    dl       = dmag_r[fsf_pkg::HW-1:0];
    hh_nxt   = fsf_pkg::HPW'(dh) * fsf_pkg::HPW'(dh);
    hl_nxt   = fsf_pkg::HPW'(dh) * fsf_pkg::HPW'(dl);
    ll_nxt   = fsf_pkg::HPW'(dl) * fsf_pkg::HPW'(dl);
    len2_nxt = fsf_pkg::LW'(sq_r[0]) + fsf_pkg::LW'(sq_r[1]) + fsf_pkg::LW'(sq_r[2]);
  end

  always_comb begin
    d2_nxt  = (fsf_pkg::PW'(hh_r) << (2 * fsf_pkg::HW))
            + (fsf_pkg::PW'(hl_r) << (fsf_pkg::HW + 1))
            + fsf_pkg::PW'(ll_r);
    deg_nxt = (len2_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      v4_r <= n_valid;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pd_r[i] <= pd_nxt[i];
      nm_r[i] <= nm_nxt[i];
      sq_r[i] <= sq_nxt[i];
    end
    dmag_r  <= dmag_nxt;
    len2_r  <= len2_nxt;
    hh_r    <= hh_nxt;
    hl_r    <= hl_nxt;
    ll_r    <= ll_nxt;
    len2b_r <= len2_r;
    d2_r    <= d2_nxt;
    deg_r   <= deg_nxt;
  end

  assign rin.valid      = v7_r;
  assign rin.degenerate = deg_r;
  assign rin.len2       = len2b_r;
  assign rin.d2         = d2_r;

endmodule

// ----- sv/fsf_root.sv -----
// ---------------------------------------------------------------------------
// fsf_root
// Bit-by-bit search for the largest q with q^2 * |n|^2 <= d^2, one result
// bit per stage, using running sums instead of multipliers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fsf_root (
  input  logic               clk,
  input  logic               rst_n,
  input  fsf_pkg::root_in_t  rin,
  output logic               out_valid,
  output fsf_pkg::shade_t    out_res
);

  localparam int QW = fsf_pkg::QW;
  localparam int PW = fsf_pkg::PW;

  // p = q^2 * len2, t = q * len2
  logic                     v_r [QW];
  logic                     g_r [QW];
  logic [fsf_pkg::LW-1:0]   l_r [QW];
  logic [PW-1:0]            d_r [QW];
  logic [PW-1:0]            p_r [QW];
  logic [PW-1:0]            t_r [QW];
  logic [QW-1:0]            q_r [QW];
  logic [PW-1:0]            p_nxt [QW];
  logic [PW-1:0]            t_nxt [QW];
  logic [QW-1:0]            q_nxt [QW];

  always_comb begin
    logic [PW-1:0]          sp, st, sd, cp;
    logic [fsf_pkg::LW-1:0] sl;
    logic [QW-1:0]          sq;
    logic                   take;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        sp = '0;
        st = '0;
        sq = '0;
        sl = rin.len2;
        sd = rin.d2;
      end else begin
        sp = p_r[k-1];
        st = t_r[k-1];
        sq = q_r[k-1];
        sl = l_r[k-1];
        sd = d_r[k-1];
      end
      // (q + 2^b)^2 L = q^2 L + 2^(b+1) q L + 2^(2b) L, with b = QW-1-k
      cp   = sp + (st << (QW - k)) + (PW'(sl) << (2 * (QW - 1 - k)));
      take = (cp <= sd);
      p_nxt[k] = take ? cp : sp;
      t_nxt[k] = take ? st + (PW'(sl) << (QW - 1 - k)) : st;
      q_nxt[k] = take ? (sq | (QW'(1) << (QW - 1 - k))) : sq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QW; k++) begin
        v_r[k] <= 1'b0;
      end
    end else begin
      v_r[0] <= rin.valid;
      for (int k = 1; k < QW; k++) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    g_r[0] <= rin.degenerate;
    l_r[0] <= rin.len2;
    d_r[0] <= rin.d2;
    for (int k = 1; k < QW; k++) begin
      g_r[k] <= g_r[k-1];
      l_r[k] <= l_r[k-1];
      d_r[k] <= d_r[k-1];
    end
    for (int k = 0; k < QW; k++) begin
      p_r[k] <= p_nxt[k];
      t_r[k] <= t_nxt[k];
      q_r[k] <= q_nxt[k];
    end
  end

  assign out_valid          = v_r[QW-1];
  assign out_res.intensity  = g_r[QW-1] ? '0 : q_r[QW-1];
  assign out_res.degenerate = g_r[QW-1];

  // the accepted square never passes the target
  `FSF_ASSERT_IMP(a_root_bound, v_r[QW-1], p_r[QW-1] <= d_r[QW-1], "root search overshoot")

endmodule

// ----- sv/flat_shade_face_intensity.sv -----
// ---------------------------------------------------------------------------
// flat_shade_face_intensity
// Flat-shading grey level of a triangle against a configured light direction.
// ---------------------------------------------------------------------------
// Usage:
//   A triangle request (three Q8.8 vertices on in_tri) is taken at each rising
//   edge with start high and busy low. busy stays low: one request per cycle.
//   Each result (Q2.14 intensity, degenerate flag) appears on out_res for one
//   cycle with out_valid high, in request order.
//   The pipeline has 7 arithmetic stages (edges, cross terms, normal, dot
//   terms, sums and squares, split square, final sum) plus a 16-stage
//   bit-serial root search, one result bit per stage.
//   The receiver cannot stall; results are never held back.
//   The light direction (Q1.14) is written through cfg_we/cfg_addr/cfg_wdata
//   while no request is in flight; addresses past light_z are ignored.
//   Reset (rst_n low, synchronous) empties the pipeline and sets the light to
//   (0, 0, 1.0).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module flat_shade_face_intensity (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  fsf_pkg::tri_t            in_tri,
  output logic                     out_valid,
  output fsf_pkg::shade_t          out_res,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_addr,
  input  logic [fsf_pkg::CW-1:0]   cfg_wdata
);

  logic signed [fsf_pkg::CW-1:0] light_x_r, light_y_r, light_z_r;
  logic                          n_valid;
  logic signed [fsf_pkg::NW-1:0] nx, ny, nz;
  fsf_pkg::root_in_t             rin;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_x_r <= '0;
      light_y_r <= '0;
      light_z_r <= fsf_pkg::CW'(16384);
    end else if (cfg_we) begin
      case (cfg_addr)
        fsf_pkg::REG_LIGHT_X: light_x_r <= cfg_wdata;
        fsf_pkg::REG_LIGHT_Y: light_y_r <= cfg_wdata;
        fsf_pkg::REG_LIGHT_Z: light_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  fsf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .in_tri   (in_tri),
    .n_valid  (n_valid),
    .nx       (nx),
    .ny       (ny),
    .nz       (nz)
  );

  fsf_dot u_dot (
    .clk     (clk),
    .rst_n   (rst_n),
    .n_valid (n_valid),
    .nx      (nx),
    .ny      (ny),
    .nz      (nz),
    .light_x (light_x_r),
    .light_y (light_y_r),
    .light_z (light_z_r),
    .rin     (rin)
  );

  fsf_root u_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .rin       (rin),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  `FSF_ASSERT_DLY(a_req_to_result, start && !busy, 23, out_valid, "result missing after request")
  `FSF_ASSERT_IMP(a_deg_dark, out_valid && out_res.degenerate, out_res.intensity == '0, "degenerate face not dark")

endmodule

// ----- sim/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Checks the flat-shading intensity pipeline against an exact integer model.
// Random and directed triangles under several light settings, random request
// gaps, and every result compared in request order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  fsf_pkg::tri_t            in_tri = '0;
  logic                     out_valid;
  fsf_pkg::shade_t          out_res;
  logic                     cfg_we = 1'b0;
  logic [1:0]               cfg_addr = '0;
  logic [fsf_pkg::CW-1:0]   cfg_wdata = '0;

  flat_shade_face_intensity i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_tri(in_tri),
    .out_valid(out_valid), .out_res(out_res), .cfg_we(cfg_we),
    .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  logic signed [fsf_pkg::CW-1:0] lx, ly, lz;   // predictor copy of the light
  fsf_pkg::tri_t   pending_tris[$];
  int              pending_gaps[$];
  fsf_pkg::shade_t expected_shades[$];
  int     errors = 0;
  int     n_checked = 0;
  int     n_degen = 0;
  int     idle_cycles = 0;
  int     gap_left = 0;

  function automatic fsf_pkg::shade_t shade_face(fsf_pkg::tri_t t);
    logic signed [16:0]  ex, ey, ez, fx, fy, fz;
    logic signed [63:0]  nx, ny, nz, d;
    logic [127:0]        len2, d2, cand;
    logic [15:0]         q;
    fsf_pkg::shade_t     r;
    ex = 17'(t.bx) - 17'(t.ax); ey = 17'(t.by) - 17'(t.ay); ez = 17'(t.bz) - 17'(t.az);
    fx = 17'(t.cx) - 17'(t.ax); fy = 17'(t.cy) - 17'(t.ay); fz = 17'(t.cz) - 17'(t.az);
    nx = 64'(ey) * 64'(fz) - 64'(ez) * 64'(fy);
    ny = 64'(ez) * 64'(fx) - 64'(ex) * 64'(fz);
    nz = 64'(ex) * 64'(fy) - 64'(ey) * 64'(fx);
    d  = nx * 64'(lx) + ny * 64'(ly) + nz * 64'(lz);
    // squares reach 66 bits, so widen before multiplying
    len2 = 128'(nx) * 128'(nx) + 128'(ny) * 128'(ny) + 128'(nz) * 128'(nz);
    r = '0;
    if (len2 == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    if (d < 0) d = -d;
    d2 = 128'(d) * 128'(d);
    q = '0;
    for (int b = 15; b >= 0; b--) begin
      cand = 128'(q | (16'd1 << b));
      if (len2 * cand * cand <= d2) q = q | (16'd1 << b);
    end
    r.intensity = q;
    return r;
  endfunction

  function automatic logic [fsf_pkg::CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_tri(fsf_pkg::tri_t t);
    pending_tris.push_back(t);
    pending_gaps.push_back(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6));
  endtask

  task automatic queue_random(int n);
    fsf_pkg::tri_t t;
    for (int i = 0; i < n; i++) begin
      t = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
           rand_coord(), rand_coord(), rand_coord(), rand_coord()};
      // some collinear or repeated vertices
      if ($urandom_range(0, 15) == 0) {t.bx, t.by, t.bz} = {t.ax, t.ay, t.az};
      if ($urandom_range(0, 15) == 0) {t.cx, t.cy, t.cz} = {t.ax, t.ay, t.az};
      queue_tri(t);
    end
  endtask

  task automatic drain();
    while (pending_tris.size() != 0 || expected_shades.size() != 0) @(posedge clk);
    repeat (fsf_pkg::LAT + 4) @(posedge clk);
  endtask

  // one write cycle, then cfg_we goes low before the next write
  task automatic write_light(fsf_pkg::cfg_reg_t idx, logic [fsf_pkg::CW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    case (idx)
      fsf_pkg::REG_LIGHT_X: lx = v;
      fsf_pkg::REG_LIGHT_Y: ly = v;
      fsf_pkg::REG_LIGHT_Z: lz = v;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // hold request
    end else begin
      if (start) begin
        expected_shades.push_back(shade_face(in_tri));
        void'(pending_tris.pop_front());
        void'(pending_gaps.pop_front());
        gap_left = (pending_gaps.size() != 0) ? pending_gaps[0] : 0;
      end
      if (pending_tris.size() != 0 && gap_left == 0) begin
        start  <= 1'b1;
        in_tri <= pending_tris[0];
      end else begin
        start <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_shades.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        fsf_pkg::shade_t e;
        e = expected_shades.pop_front();
        n_checked++;
        if (e.degenerate) n_degen++;
        if (out_res.intensity !== e.intensity) begin
          $error("intensity expected %0d got %0d", e.intensity, out_res.intensity);
          errors++;
        end
        if (out_res.degenerate !== e.degenerate) begin
          $error("degenerate expected %0d got %0d", e.degenerate, out_res.degenerate);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any request or result
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    lx = 16'sd0; ly = 16'sd0; lz = 16'sd16384;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: degenerate, extremes, unit triangle, zero light later
    queue_tri('0);
    queue_tri({9{16'h8000}});
    queue_tri({16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
               16'h8000, 16'h7fff, 16'h8000});
    queue_tri({16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff,
               16'h7fff, 16'h8000, 16'h7fff});
    queue_tri({16'h0, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h0100, 16'h0});
    queue_tri({16'h0, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0100});
    queue_tri({16'h0, 16'h0, 16'h0, 16'h0100, 16'h0100, 16'h0, 16'h0200, 16'h0200, 16'h0});
    queue_tri({16'hffff, 16'h0, 16'h0, 16'h0, 16'hffff, 16'h0, 16'h0, 16'h0, 16'hffff});
    queue_random(10);
    drain();   // sender holds off until everything is back

    write_light(fsf_pkg::REG_LIGHT_X, 16'h8000);
    write_light(fsf_pkg::REG_LIGHT_Y, 16'h7fff);
    write_light(fsf_pkg::REG_LIGHT_Z, 16'h8000);
    queue_random(200);
    drain();

    write_light(fsf_pkg::REG_LIGHT_X, 16'h0);
    write_light(fsf_pkg::REG_LIGHT_Y, 16'h0);
    write_light(fsf_pkg::REG_LIGHT_Z, 16'h0);
    queue_tri({16'h0, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h0100, 16'h0});
    queue_random(40);
    drain();

    write_light(fsf_pkg::REG_LIGHT_X, 16'h2d41);
    write_light(fsf_pkg::REG_LIGHT_Y, 16'hd2bf);
    write_light(fsf_pkg::REG_LIGHT_Z, 16'h7fff);
    queue_random(250);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_light(fsf_pkg::REG_LIGHT_X, 16'($urandom));
      write_light(fsf_pkg::REG_LIGHT_Y, 16'($urandom));
      write_light(fsf_pkg::REG_LIGHT_Z, 16'($urandom));
      queue_random(125);
      drain();
    end

    $display("checked %0d shaded faces (%0d degenerate) over 8 light settings",
             n_checked, n_degen);
    if (errors == 0 && expected_shades.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
